// ===== rtl/jct_pkg.sv =====
// jct_pkg: widths, stage counts, register indexes and hash helpers for
// the jittered coarse timer. No dependencies.
`default_nettype none

package jct_pkg;

	localparam int TW       = 64;             // raw count and result width
	localparam int FW       = 34;             // counter frequency width
	localparam int QW       = 21;             // quantum width (max freq / 10000)
	localparam int SW       = TW + 1;         // rounded-up floor width
	localparam int PW       = SW + 20;        // floor * 1e6 width
	localparam int DSTEP    = 4;              // quotient bits per divider stage

	// quantum = freq / 10000 = (freq >> 4) / 625, the last step by reciprocal
	// multiply: ceil(2^40 / 625), exact for any 30-bit dividend
	localparam int             Q_PRE   = 4;
	localparam int             Q_SHIFT = 40;
	localparam int             QRW     = 31;
	localparam logic [QRW-1:0] Q_RECIP = 31'd1759218605;
	localparam int             QPW     = FW - Q_PRE + QRW;

	localparam int A_ST = TW / DSTEP;         // raw mod quantum stages
	localparam int B_ST = 32 / DSTEP;         // hash mod quantum stages
	localparam int C_NW = 88;                 // microsecond dividend, padded to DSTEP
	localparam int C_ST = C_NW / DSTEP;       // microsecond divider stages
	localparam int NS   = A_ST + B_ST + C_ST + 13;

	localparam int        CIW        = 2;
	localparam logic [CIW-1:0] CFG_FREQ   = 2'd0;
	localparam logic [CIW-1:0] CFG_CTX    = 2'd1;
	localparam logic [CIW-1:0] CFG_SECRET = 2'd2;

	localparam logic [31:0] CTX_RESET = 32'h1234_5678;
	localparam logic [31:0] MM_C1     = 32'hcc9e_2d51;
	localparam logic [31:0] MM_C2     = 32'h1b87_3593;
	localparam logic [31:0] MM_N      = 32'he654_6b64;
	localparam logic [31:0] MM_F1     = 32'h85eb_ca6b;
	localparam logic [31:0] MM_F2     = 32'hc2b2_ae35;
	localparam logic [31:0] MM_LEN    = 32'd12;
	localparam logic [19:0] US_PER_S  = 20'd1000000;

	typedef struct packed {
		logic [TW-1:0] raw;
		logic [TW-1:0] floor_v;
		logic [QW-1:0] off;
	} carry_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	// h ^= k; h = rotl(h, 13); h = h * 5 + n
	function automatic logic [31:0] mm_mix_h(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] t;
		t = rotl32(h ^ k, 13);
		return (t << 2) + t + MM_N;
	endfunction

	function automatic logic [31:0] mm_fmix16(input logic [31:0] h);
		return h ^ (h >> 16);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/jittered_coarse_timer.sv =====
// jittered_coarse_timer: fully pipelined coarse timestamp with keyed jitter.
// Depends on jct_pkg.
`default_nettype none

// One request per cycle through 59 register stages, while the output is not
// stalled and no quantum is being derived. The pipeline is: 16 stages
// of raw mod quantum (4 bits each), one floor subtract, 8 stages of
// MurmurHash3, 8 stages of hash mod quantum, one threshold add, two stages
// of multiply by 1e6, 22 stages of the microsecond divide by counter_freq_hz,
// and the output register.
// The whole pipeline advances together when the output is empty or taken.
// After a write to counter_freq_hz the quantum is derived by a reciprocal
// multiply in the following cycle; in_ready is low for that cycle.
// Configuration writes are always taken (cfg_ready is tied high); index 3 is
// ignored. With a quantum of zero the raw count passes through with bypassed set.
module jittered_coarse_timer (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [jct_pkg::CIW-1:0]  cfg_index,
	input  wire  [jct_pkg::FW-1:0]   cfg_data,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [jct_pkg::TW-1:0]   raw_cycles,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [jct_pkg::TW-1:0]   time_value,
	output logic                     bypassed
);
	import jct_pkg::*;

	function automatic logic [QW-1:0] modq_step(input logic [QW-1:0] r,
			input logic [DSTEP-1:0] b, input logic [QW-1:0] d);
		logic [QW:0]   t;
		logic [QW-1:0] x;
		x = r;
		for (int j = DSTEP - 1; j >= 0; j--) begin
			t = {x, b[j]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			x = t[QW-1:0];
		end
		return x;
	endfunction

	// returns {remainder, quotient bits}
	function automatic logic [FW+DSTEP-1:0] divf_step(input logic [FW-1:0] r,
			input logic [DSTEP-1:0] b, input logic [FW-1:0] d);
		logic [FW:0]      t;
		logic [FW-1:0]    x;
		logic [DSTEP-1:0] qb;
		x  = r;
		qb = '0;
		for (int j = DSTEP - 1; j >= 0; j--) begin
			t = {x, b[j]};
			if (t >= {1'b0, d}) begin
				t     = t - {1'b0, d};
				qb[j] = 1'b1;
			end
			x = t[FW-1:0];
		end
		return {x, qb};
	endfunction

	// ---------------- configuration and quantum ----------------
	logic [FW-1:0]  freq_q;
	logic [31:0]    ctx_q;
	logic [31:0]    secret_q;
	logic [QW-1:0]  q_q;
	logic           qd_busy_q;
	logic [QPW-1:0] qd_prod;
	logic           busy;
	logic [QW-1:0]  q_w;
	logic           bypass_w;

	assign cfg_ready = 1'b1;
	assign busy      = qd_busy_q;
	assign q_w       = q_q;
	assign bypass_w  = q_w == '0;
	assign qd_prod   = QPW'(freq_q[FW-1:Q_PRE]) * QPW'(Q_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q    <= '0;
			ctx_q     <= CTX_RESET;
			secret_q  <= '0;
			q_q       <= '0;
			qd_busy_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index == CFG_FREQ) begin
				freq_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_CTX) begin
				ctx_q <= cfg_data[31:0];
			end
			if (cfg_valid && cfg_ready && cfg_index == CFG_SECRET) begin
				secret_q <= cfg_data[31:0];
			end
			// the quantum register follows freq_q in the next cycle
			qd_busy_q <= cfg_valid && cfg_ready && cfg_index == CFG_FREQ;
			q_q       <= qd_prod[Q_SHIFT +: QW];
		end
	end

	// ---------------- pipeline control ----------------
	logic [NS-1:0] v_q;
	logic          adv;
	logic          take;

	assign adv       = !v_q[NS-1] || out_ready;
	assign in_ready  = adv && !busy;
	assign take      = in_valid && in_ready;
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], take};
		end
	end

	// ---------------- raw mod quantum ----------------
	logic [QW-1:0] a_rem_s [A_ST];
	logic [TW-1:0] a_raw_s [A_ST];
	carry_t        f_c_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_rem_s[0] <= modq_step('0, raw_cycles[TW-1 -: DSTEP], q_w);
			a_raw_s[0] <= raw_cycles;
			for (int k = 1; k < A_ST; k++) begin
				a_rem_s[k] <= modq_step(a_rem_s[k-1],
					a_raw_s[k-1][TW-1-DSTEP*k -: DSTEP], q_w);
				a_raw_s[k] <= a_raw_s[k-1];
			end
			f_c_s1.raw     <= a_raw_s[A_ST-1];
			f_c_s1.off     <= a_rem_s[A_ST-1];
			f_c_s1.floor_v <= a_raw_s[A_ST-1] - TW'(a_rem_s[A_ST-1]);
		end
	end

	// ---------------- MurmurHash3 of (floor, context) ----------------
	carry_t      h_c_s [8];
	logic [31:0] ka_s1, kb_s1, kc_s1;
	logic [31:0] ka_s2, kb_s2, kc_s2;
	logic [31:0] kb_s3, kc_s3, kc_s4;
	logic [31:0] hh_s3, hh_s4, hh_s5, hh_s6, hh_s7, hh_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_c_s[0] <= f_c_s1;
			for (int k = 1; k < 8; k++) begin
				h_c_s[k] <= h_c_s[k-1];
			end
			ka_s1 <= f_c_s1.floor_v[31:0] * MM_C1;
			kb_s1 <= f_c_s1.floor_v[63:32] * MM_C1;
			kc_s1 <= ctx_q * MM_C1;
			ka_s2 <= rotl32(ka_s1, 15) * MM_C2;
			kb_s2 <= rotl32(kb_s1, 15) * MM_C2;
			kc_s2 <= rotl32(kc_s1, 15) * MM_C2;
			hh_s3 <= mm_mix_h(secret_q, ka_s2);
			kb_s3 <= kb_s2;
			kc_s3 <= kc_s2;
			hh_s4 <= mm_mix_h(hh_s3, kb_s3);
			kc_s4 <= kc_s3;
			hh_s5 <= mm_fmix16(mm_mix_h(hh_s4, kc_s4) ^ MM_LEN);
			hh_s6 <= hh_s5 * MM_F1;
			hh_s7 <= (hh_s6 ^ (hh_s6 >> 13)) * MM_F2;
			hh_s8 <= mm_fmix16(hh_s7);
		end
	end

	// ---------------- hash mod quantum, threshold ----------------
	logic [QW-1:0] b_rem_s  [B_ST];
	logic [31:0]   b_hash_s [B_ST];
	carry_t        b_c_s    [B_ST];
	logic [SW-1:0] s_sum_s1;
	logic [TW-1:0] s_raw_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			b_rem_s[0]  <= modq_step('0, hh_s8[31 -: DSTEP], q_w);
			b_hash_s[0] <= hh_s8;
			b_c_s[0]    <= h_c_s[7];
			for (int k = 1; k < B_ST; k++) begin
				b_rem_s[k]  <= modq_step(b_rem_s[k-1],
					b_hash_s[k-1][31-DSTEP*k -: DSTEP], q_w);
				b_hash_s[k] <= b_hash_s[k-1];
				b_c_s[k]    <= b_c_s[k-1];
			end
			// round up when the offset reaches the jitter point
			s_sum_s1 <= {1'b0, b_c_s[B_ST-1].floor_v} +
				((b_c_s[B_ST-1].off >= b_rem_s[B_ST-1]) ? SW'(q_w) : SW'(0));
			s_raw_s1 <= b_c_s[B_ST-1].raw;
		end
	end

	// ---------------- multiply by 1e6 ----------------
	logic [51:0]   p_lo_s1;
	logic [52:0]   p_hi_s1;
	logic [TW-1:0] p_raw_s1;
	logic [PW-1:0] p_prod_s2;
	logic [TW-1:0] p_raw_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_lo_s1   <= 52'(s_sum_s1[31:0]) * 52'(US_PER_S);
			p_hi_s1   <= 53'(s_sum_s1[SW-1:32]) * 53'(US_PER_S);
			p_raw_s1  <= s_raw_s1;
			p_prod_s2 <= PW'(p_lo_s1) + {p_hi_s1, 32'b0};
			p_raw_s2  <= p_raw_s1;
		end
	end

	// ---------------- divide by counter frequency ----------------
	logic [C_NW-1:0]       c_num0;
	logic [FW+DSTEP-1:0]   c_nx    [C_ST];
	logic [FW-1:0]         c_rem_s [C_ST];
	logic [C_NW-1:0]       c_num_s [C_ST];
	logic [TW-1:0]         c_raw_s [C_ST];
	logic [C_NW-1:0]       quo;
	logic                  sat;

	assign c_num0 = C_NW'(p_prod_s2);

	always_comb begin
		c_nx[0] = divf_step('0, c_num0[C_NW-1 -: DSTEP], freq_q);
		for (int k = 1; k < C_ST; k++) begin
			c_nx[k] = divf_step(c_rem_s[k-1], c_num_s[k-1][C_NW-1 -: DSTEP], freq_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_rem_s[0] <= c_nx[0][FW+DSTEP-1:DSTEP];
			c_num_s[0] <= {c_num0[C_NW-DSTEP-1:0], c_nx[0][DSTEP-1:0]};
			c_raw_s[0] <= p_raw_s2;
			for (int k = 1; k < C_ST; k++) begin
				c_rem_s[k] <= c_nx[k][FW+DSTEP-1:DSTEP];
				c_num_s[k] <= {c_num_s[k-1][C_NW-DSTEP-1:0], c_nx[k][DSTEP-1:0]};
				c_raw_s[k] <= c_raw_s[k-1];
			end
		end
	end

	// ---------------- output register ----------------
	assign quo = c_num_s[C_ST-1];
	assign sat = |quo[C_NW-1:TW];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (bypass_w) begin
				time_value <= c_raw_s[C_ST-1];
			end else if (sat) begin
				time_value <= '1;
			end else begin
				time_value <= quo[TW-1:0];
			end
			bypassed <= bypass_w;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("request taken while quantum is derived");
	a_freq_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == CFG_FREQ |=> busy)
		else $error("frequency write did not hold off requests");
	a_quantum_settled: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> q_q == qd_prod[Q_SHIFT +: QW])
		else $error("quantum stale while requests are taken");
	a_take_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_q[0])
		else $error("accepted request lost its valid bit");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for jittered_coarse_timer. It predicts each coarse,
// jittered timestamp, compares it with the block's output and reports the result.
// Depends on jct_pkg and the jittered_coarse_timer RTL.

module tb;
	import jct_pkg::*;

	localparam logic [CIW-1:0] CFG_UNUSED = 2'd3;   // index the block ignores
	localparam int             LIMIT      = 600000;
	localparam int             DRAIN      = 80;     // drain margin beyond the pipeline depth
	localparam logic [TW-1:0]  ALL1       = '1;

	typedef enum bit {ROW_CFG, ROW_REQ} row_kind_e;

	typedef struct {
		row_kind_e      kind;
		logic [CIW-1:0] idx;
		logic [FW-1:0]  data;
		logic [TW-1:0]  raw;
		bit             typed;    // expected value given in the row
		logic [TW-1:0]  t;
		bit             b;
	} row_t;

	typedef struct packed {
		logic [TW-1:0] t;
		logic          b;
	} stamp_t;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           cfg_valid = 0;
	logic           cfg_ready;
	logic [CIW-1:0] cfg_index = '0;
	logic [FW-1:0]  cfg_data = '0;
	logic           in_valid = 0;
	logic           in_ready;
	logic [TW-1:0]  raw_cycles = '0;
	logic           out_valid;
	logic           out_ready = 0;
	logic [TW-1:0]  time_value;
	logic           bypassed;

	// shadow copy of the block's registers
	logic [FW-1:0] freq_hz = '0;
	logic [31:0]   ctx_word = CTX_RESET;
	logic [31:0]   hash_seed = '0;

	stamp_t stamps_due[$];
	int     mismatches = 0;
	int     stamps_seen = 0;
	int     reqs_sent = 0;
	int     cycles = 0;
	int     tx_burst = 0;
	int     rx_burst = 0;

	jittered_coarse_timer DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .raw_cycles(raw_cycles),
		.out_valid(out_valid), .out_ready(out_ready), .time_value(time_value),
		.bypassed(bypassed)
	);

	always #5 clk = ~clk;

	// MurmurHash3 x86_32 over (floor lo, floor hi, context), 12 bytes
	function automatic logic [31:0] mm_round(logic [31:0] h, logic [31:0] k);
		k = k * MM_C1;
		k = {k[16:0], k[31:17]};
		k = k * MM_C2;
		h = h ^ k;
		h = {h[18:0], h[31:19]};
		return h * 32'd5 + MM_N;
	endfunction

	function automatic logic [31:0] tuple_hash(logic [63:0] fl);
		logic [31:0] h;
		h = mm_round(hash_seed, fl[31:0]);
		h = mm_round(h, fl[63:32]);
		h = mm_round(h, ctx_word);
		h = h ^ MM_LEN;
		h = h ^ (h >> 16);
		h = h * MM_F1;
		h = h ^ (h >> 13);
		h = h * MM_F2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// coarse timestamp in microseconds for one raw count under current registers
	function automatic stamp_t coarse_stamp(logic [TW-1:0] raw);
		logic [63:0]  quantum, off, fl, hq;
		logic [64:0]  rounded;
		logic [127:0] usec;
		stamp_t       s;
		quantum = {30'b0, freq_hz} / 64'd10000;
		if (quantum == 0) begin
			s.t = raw;
			s.b = 1'b1;
			return s;
		end
		off = raw % quantum;
		fl  = raw - off;
		hq  = {32'b0, tuple_hash(fl)} % quantum;
		rounded = {1'b0, fl};
		if (off >= hq)
			rounded = rounded + {1'b0, quantum};   // may carry into bit 64
		usec = ({63'b0, rounded} * 128'd1000000) / {94'b0, freq_hz};
		s.t = (usec[127:64] != 0) ? ALL1 : usec[63:0];
		s.b = 1'b0;
		return s;
	endfunction

	// output monitor: oldest expectation against each accepted result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, stamps_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			stamps_seen <= stamps_seen + 1;
			if (stamps_due.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result time=%h byp=%b", time_value, bypassed);
			end else begin
				stamp_t e;
				e = stamps_due.pop_front();
				if (e.t !== time_value || e.b !== bypassed) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch #%0d: exp time=%h byp=%b, got time=%h byp=%b",
							stamps_seen, e.t, e.b, time_value, bypassed);
				end
			end
		end
	end

	// result side: random back-pressure, bursts of none, one long hold-off
	initial begin
		int  w;
		bit  held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (!held && stamps_seen >= 300) begin
				// long stall: pipeline fills up and in_ready must drop
				held = 1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (rx_burst > 0) begin
				rx_burst--;
				w = 0;
			end else begin
				w = $urandom_range(0, 13);
				if ($urandom_range(0, 7) == 0)
					rx_burst = $urandom_range(10, 40);
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (stamps_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIW-1:0] idx, logic [FW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FREQ:   freq_hz = data;
			CFG_CTX:    ctx_word = data[31:0];
			CFG_SECRET: hash_seed = data[31:0];
			default:    ;
		endcase
	endtask

	// one request; valid stays up across back-to-back requests
	task automatic send_req(logic [TW-1:0] raw, bit typed, stamp_t given);
		int gap;
		if (tx_burst > 0) begin
			tx_burst--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 13);
			if ($urandom_range(0, 7) == 0)
				tx_burst = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_cycles <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		stamps_due.push_back(typed ? given : coarse_stamp(raw));
		reqs_sent++;
	endtask

	function automatic logic [FW-1:0] pick_freq();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return 34'd9999;
			2: return FW'($urandom_range(10000, 40000));
			3: return '1;
			4: return {2'($urandom_range(0, 3)),
				32'd3_000_000_000 ^ 32'($urandom_range(0, 65535))};
			default: return {2'($urandom), $urandom};
		endcase
	endfunction

	function automatic logic [TW-1:0] pick_raw();
		logic [63:0] r, q;
		r = {$urandom, $urandom};
		q = {30'b0, freq_hz} / 64'd10000;
		case ($urandom_range(0, 5))
			0: return r;
			1: return 64'($urandom_range(0, 100000));
			2: return ALL1 - 64'($urandom_range(0, 5000000));
			3: return 64'd1 << $urandom_range(0, 63);
			4: return (q == 0) ? r : (r - r % q + 64'($urandom_range(0, 3)));
			default: return (q == 0) ? ~r : (r - r % q - 64'($urandom_range(1, 2)));
		endcase
	endfunction

	// directed rows: reset state, bypass, unit quantum, extremes, ignored index
	row_t dir_rows [22] = '{
		'{ROW_REQ, CFG_FREQ,   '0,            64'd0,                  1, 64'd0,       1},
		'{ROW_REQ, CFG_FREQ,   '0,            ALL1,                   1, ALL1,        1},
		'{ROW_REQ, CFG_FREQ,   '0,            64'h0123456789abcdef,   1, 64'h0123456789abcdef, 1},
		'{ROW_CFG, CFG_FREQ,   34'd9999,      '0,                     0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'h8000000000000000,   1, 64'h8000000000000000, 1},
		'{ROW_CFG, CFG_FREQ,   34'd10000,     '0,                     0, '0,          0},
		// unit quantum: always rounds up, 100 us per count
		'{ROW_REQ, CFG_FREQ,   '0,            64'd0,                  1, 64'd100,     0},
		'{ROW_REQ, CFG_FREQ,   '0,            ALL1,                   1, ALL1,        0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'd184467440737095515, 0, '0,          0},
		'{ROW_CFG, CFG_UNUSED, '1,            '0,                     0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'd41,                 1, 64'd4200,    0},
		'{ROW_CFG, CFG_FREQ,   '1,            '0,                     0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            ALL1,                   0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'd0,                  0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'hfffffffffff00000,   0, '0,          0},
		'{ROW_CFG, CFG_CTX,    34'h0,         '0,                     0, '0,          0},
		'{ROW_CFG, CFG_SECRET, 34'hffffffff,  '0,                     0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'h5555555555555555,   0, '0,          0},
		'{ROW_CFG, CFG_CTX,    34'hffffffff,  '0,                     0, '0,          0},
		'{ROW_CFG, CFG_SECRET, 34'h0,         '0,                     0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'haaaaaaaaaaaaaaaa,   0, '0,          0},
		'{ROW_REQ, CFG_FREQ,   '0,            64'h7fffffffffffffff,   0, '0,          0}
	};

	initial begin
		stamp_t s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				s.t = dir_rows[i].t;
				s.b = dir_rows[i].b;
				send_req(dir_rows[i].raw, dir_rows[i].typed, s);
			end
		end

		// random phases, each under fresh register settings
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: write_reg(CFG_FREQ, '1);
				1: write_reg(CFG_FREQ, 34'd9999);
				2: write_reg(CFG_FREQ, 34'd10000);
				default: write_reg(CFG_FREQ, pick_freq());
			endcase
			write_reg(CFG_CTX, {2'b0, $urandom});
			write_reg(CFG_SECRET, {2'b0, $urandom});
			for (int n = 0; n < 160; n++) begin
				if (ph == 3 && n == 80) begin
					// sender pause until every result is back
					in_valid <= 1'b0;
					@(posedge clk);
					while (stamps_due.size() != 0) @(posedge clk);
				end
				s = '0;
				send_req(pick_raw(), 0, s);
			end
		end

		wait_drained();
		$display("covered %0d requests, %0d results over directed rows and 8 register settings",
			reqs_sent, stamps_seen);
		$display("bypass, unit quantum, max frequency, seed extremes and output stalls exercised");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
